>>> rtl/core/hed_pkg.sv
// Types, constants and entity tables shared by the HTML entity decoder modules.
package hed_pkg;

  // Entity set and hold buffer geometry
  localparam int NUM_ENT    = 6;
  localparam int HOLD_DEPTH = 6;
  localparam int CNT_W      = 3;
  localparam int ENT_W      = 3;

  // Characters with a special role
  localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CH_SEMI  = 8'h3b;  // ';'
  localparam logic [7:0] CH_QUOT  = 8'h22;  // '"'
  localparam logic [7:0] CH_APOS  = 8'h27;  // '\''
  localparam logic [7:0] CH_SLASH = 8'h2f;  // '/'
  localparam logic [7:0] CH_GT    = 8'h3e;  // '>'
  localparam logic [7:0] CH_LT    = 8'h3c;  // '<'

  // Entity indexes, also the bit positions of the viable mask
  localparam logic [ENT_W-1:0] ENT_QUOT  = 3'd0;
  localparam logic [ENT_W-1:0] ENT_APOS  = 3'd1;
  localparam logic [ENT_W-1:0] ENT_AMP   = 3'd2;
  localparam logic [ENT_W-1:0] ENT_GT    = 3'd3;
  localparam logic [ENT_W-1:0] ENT_LT    = 3'd4;
  localparam logic [ENT_W-1:0] ENT_FRASL = 3'd5;

  // Entity spellings, character 0 in the lowest byte
  localparam logic [7:0][7:0] TXT_QUOT  = {8'h00, 8'h00, CH_SEMI, "t", "o", "u", "q", CH_AMP};
  localparam logic [7:0][7:0] TXT_APOS  = {8'h00, 8'h00, CH_SEMI, "s", "o", "p", "a", CH_AMP};
  localparam logic [7:0][7:0] TXT_AMP   = {8'h00, 8'h00, 8'h00, CH_SEMI, "p", "m", "a", CH_AMP};
  localparam logic [7:0][7:0] TXT_GT    = {8'h00, 8'h00, 8'h00, 8'h00, CH_SEMI, "t", "g", CH_AMP};
  localparam logic [7:0][7:0] TXT_LT    = {8'h00, 8'h00, 8'h00, 8'h00, CH_SEMI, "t", "l", CH_AMP};
  localparam logic [7:0][7:0] TXT_FRASL = {8'h00, CH_SEMI, "l", "s", "a", "r", "f", CH_AMP};

  // One request from the classifier to the output serializer: the first cnt
  // held bytes, then the tail byte when tail_vld is set.
  typedef struct packed {
    logic [HOLD_DEPTH-1:0][7:0] held;
    logic [CNT_W-1:0]           cnt;
    logic                       tail_vld;
    logic [7:0]                 tail;
    logic                       last;
  } hed_cmd_t;

  // Character of an entity at a given position
  function automatic logic [7:0] ent_text_at(input logic [ENT_W-1:0] e,
                                             input logic [CNT_W-1:0] pos);
    logic [7:0] ch;
    unique case (e)
      ENT_QUOT:  ch = TXT_QUOT[pos];
      ENT_APOS:  ch = TXT_APOS[pos];
      ENT_AMP:   ch = TXT_AMP[pos];
      ENT_GT:    ch = TXT_GT[pos];
      ENT_LT:    ch = TXT_LT[pos];
      ENT_FRASL: ch = TXT_FRASL[pos];
      default:   ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Length of an entity including '&' and ';'
  function automatic logic [CNT_W-1:0] ent_len(input logic [ENT_W-1:0] e);
    logic [CNT_W-1:0] len;
    unique case (e)
      ENT_QUOT:  len = 3'd6;
      ENT_APOS:  len = 3'd6;
      ENT_AMP:   len = 3'd5;
      ENT_GT:    len = 3'd4;
      ENT_LT:    len = 3'd4;
      ENT_FRASL: len = 3'd7;
      default:   len = 3'd0;
    endcase
    return len;
  endfunction

  // Decoded character of an entity
  function automatic logic [7:0] ent_char(input logic [ENT_W-1:0] e);
    logic [7:0] ch;
    unique case (e)
      ENT_QUOT:  ch = CH_QUOT;
      ENT_APOS:  ch = CH_APOS;
      ENT_AMP:   ch = CH_AMP;
      ENT_GT:    ch = CH_GT;
      ENT_LT:    ch = CH_LT;
      ENT_FRASL: ch = CH_SLASH;
      default:   ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/core/hed_front.sv
// Front end: tracks the partial entity match; a byte is held in it or becomes a request.
module hed_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,        // byte accepted this cycle
  input  logic [7:0]        char_in,
  input  logic              last_in,
  output logic              push,
  output hed_pkg::hed_cmd_t cmd
);

  logic [hed_pkg::HOLD_DEPTH-1:0][7:0] held_r, held_nxt;
  logic [hed_pkg::CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [hed_pkg::NUM_ENT-1:0]         viable_r, viable_nxt;

  logic [hed_pkg::NUM_ENT-1:0] mask;
  logic                        done;
  logic [7:0]                  done_char;
  logic                        is_amp;
  logic                        can_extend;

  // Compare the byte against every still-viable entity at the current position
  always_comb begin
    mask      = '0;
    done      = 1'b0;
    done_char = 8'h00;
    for (int e = 0; e < hed_pkg::NUM_ENT; e++) begin
      if (viable_r[e] && (cnt_r < hed_pkg::ent_len(3'(e))) &&
          (hed_pkg::ent_text_at(3'(e), cnt_r) == char_in)) begin
        mask[e] = 1'b1;
        if (cnt_r + 3'd1 == hed_pkg::ent_len(3'(e))) begin
          done      = 1'b1;
          done_char = hed_pkg::ent_char(3'(e));
        end
      end
    end
  end

  assign is_amp     = (char_in == hed_pkg::CH_AMP);
  assign can_extend = (mask != '0) && (cnt_r < 3'(hed_pkg::HOLD_DEPTH));

  // Next match state and the request for this byte
  always_comb begin
    held_nxt     = held_r;
    cnt_nxt      = cnt_r;
    viable_nxt   = viable_r;
    cmd.held     = held_r;
    cmd.cnt      = '0;
    cmd.tail_vld = 1'b0;
    cmd.tail     = char_in;
    cmd.last     = last_in;
    if (cnt_r != '0 && done) begin
      // Entity complete: emit its character
      cmd.tail     = done_char;
      cmd.tail_vld = 1'b1;
      cnt_nxt      = '0;
      viable_nxt   = '0;
    end else if (cnt_r != '0 && can_extend) begin
      if (last_in) begin
        // Final byte inside a match: flush held bytes and this byte
        cmd.cnt      = cnt_r;
        cmd.tail_vld = 1'b1;
        cnt_nxt      = '0;
        viable_nxt   = '0;
      end else begin
        held_nxt[cnt_r] = char_in;
        cnt_nxt         = cnt_r + 3'd1;
        viable_nxt      = mask;
      end
    end else begin
      // Failed match or nothing held: flush, then treat the byte afresh
      cmd.cnt = cnt_r;
      if (is_amp && !last_in) begin
        held_nxt[0] = char_in;
        cnt_nxt     = 3'd1;
        viable_nxt  = '1;
      end else begin
        cmd.tail_vld = 1'b1;
        cnt_nxt      = '0;
        viable_nxt   = '0;
      end
    end
  end

  assign push = acc && ((cmd.cnt != '0) || cmd.tail_vld);

  // Match state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      viable_r <= '0;
    end else if (acc) begin
      cnt_r    <= cnt_nxt;
      viable_r <= viable_nxt;
    end
  end

  // Held bytes carry no reset; only entries below the count are read
  always_ff @(posedge clk) begin
    if (acc) begin
      held_r <= held_nxt;
    end
  end

endmodule

>>> rtl/core/hed_queue.sv
// Short request queue between the front end and the output serializer.
module hed_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hed_pkg::hed_cmd_t push_data,
  input  logic              pop,
  output hed_pkg::hed_cmd_t head,
  output logic              not_empty,
  output logic              full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hed_pkg::hed_cmd_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  level_r, level_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (level_r == CNT_W'(DEPTH));
  assign not_empty = (level_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  // Pointer and level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    level_nxt  = level_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      level_nxt = level_r + 1'b1;
    end else if (do_pop && !do_push) begin
      level_nxt = level_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/core/hed_back.sv
// Back end: head request to output register, one byte per cycle unless stalled.
module hed_back (
  input  logic              clk,
  input  logic              rst_n,
  input  hed_pkg::hed_cmd_t head,
  input  logic              head_vld,
  output logic              pop,
  output logic              out_vld,
  input  logic              out_rdy,
  output logic [7:0]        out_char,
  output logic              out_last,
  output logic              out_text_end
);

  logic [hed_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic                      vld_r;
  logic [7:0]                char_r;
  logic                      last_r;
  logic                      end_r;

  logic [hed_pkg::CNT_W-1:0] total;
  logic                      final_byte;
  logic [7:0]                cur_char;
  logic                      load;

  // Byte selection within the head request
  assign total      = head.cnt + {{(hed_pkg::CNT_W-1){1'b0}}, head.tail_vld};
  assign final_byte = (idx_r + 3'd1 == total);
  assign cur_char   = (idx_r < head.cnt) ? head.held[idx_r] : head.tail;
  assign load       = head_vld && (!vld_r || out_rdy);
  assign pop        = load && final_byte;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = final_byte ? '0 : idx_r + 3'd1;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        vld_r <= 1'b1;
      end else if (out_rdy) begin
        vld_r <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= cur_char;
      last_r <= final_byte;
      end_r  <= final_byte && head.last;
    end
  end

  assign out_vld      = vld_r;
  assign out_char     = char_r;
  assign out_last     = last_r;
  assign out_text_end = end_r;

endmodule

>>> rtl/core/html_entity_decoder.sv
// Top level of the HTML entity decoder: classifier, request queue and output serializer.
//
//   Channel | Direction | Payload
//   in_     | sink      | tdata: char[7:0]; tlast: final byte of the text
//   out_    | source    | tdata: char[7:0]; tlast: last byte for its input; tuser: text end
//
// One input byte is accepted per cycle while the request queue has room; one
// output byte leaves per cycle from the output register while out_tready is high. A byte
// that completes or passes through yields one output byte; a failed match or a final byte
// inside an unfinished match flushes up to six held bytes, one per cycle while out_tready
// is high, and the QUEUE_DEPTH-entry queue absorbs such bursts. Reset clears the match
// state, queue and output valid. in_tready falls only while the queue is full.
module html_entity_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast,
  output logic       out_tuser   // [0] out_text_end
);

  hed_pkg::hed_cmd_t cmd;
  hed_pkg::hed_cmd_t head;
  logic              push;
  logic              pop;
  logic              head_vld;
  logic              q_full;
  logic              acc;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  hed_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .char_in (in_tdata),
    .last_in (in_tlast),
    .push    (push),
    .cmd     (cmd)
  );

  hed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cmd),
    .pop       (pop),
    .head      (head),
    .not_empty (head_vld),
    .full      (q_full)
  );

  hed_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .head_vld     (head_vld),
    .pop          (pop),
    .out_vld      (out_tvalid),
    .out_rdy      (out_tready),
    .out_char     (out_tdata),
    .out_last     (out_tlast),
    .out_text_end (out_tuser)
  );

endmodule
